### design/tsw_pkg.sv
package tsw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 4;

  localparam int DIM_W  = 11;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CIDX_W = 2;

  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W = OBUF_PTR_W + 1;

  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SUBITERATION = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             pix;
    logic             in_frame;
    logic             col_ok;
  } tsw_stage_t;

  typedef struct packed {
    logic pixel_out;
    logic cleared;
    logic frame_last;
    logic frame_changed;
  } tsw_result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(MIN_DIM)) begin
      r = DIM_W'(MIN_DIM);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### design/thinning_subiteration_window_core.sv
// Zhang-Suen thinning, one sub-iteration pass over a binary raster.
// Input channel (in_valid/in_stall): one beat per pixel in raster order,
//   in_drain marks flush beats. A frame is width*height pixel beats then
//   width+1 drain beats; the first width+1 beats of a frame give no result.
// Output channel (out_valid/out_stall): one beat per pixel, delayed by
//   width+1 input beats. out_frame_last flags the final pixel and carries
//   out_frame_changed, set if any pixel of the frame was cleared.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//   image_width, image_height and subiteration only while the block is idle.
// Throughput: one beat per cycle while in_stall is low. Each beat reads both
//   line stores at its column in the accept cycle and writes them back in the
//   next cycle; the stage 1 result is pushed to the buffer, raising out_valid.
// A four-entry output buffer takes results while out_stall is high;
//   in_stall rises once the buffer plus the beat in flight could fill it.
// Reset (rst_n low, synchronous) returns registers to 640x480, first
//   sub-iteration, position zero, buffer empty. Line store contents are
//   not cleared; entries read before they are written only reach border pixels.
module thinning_subiteration_window_core import tsw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_pixel_in,
  input  logic              in_drain,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_pixel_out,
  output logic              out_cleared,
  output logic              out_frame_last,
  output logic              out_frame_changed,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             subiter_r;
  logic [DIM_W-1:0] w, h;

  logic [DIM_W-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [DIM_W:0]   col_inc;
  logic             in_accept;

  logic line_upper [MAX_WIDTH];
  logic line_middle [MAX_WIDTH];
  logic rd_u_r, rd_m_r;

  tsw_stage_t s1_r, s1_nxt;

  logic [8:0]       win_r, win_nxt;
  logic             any_cleared_r, any_cleared_nxt;
  logic             u, m, l;
  logic             emit, border, del, last, center;
  logic [DIM_W-1:0] orow, ocol;
  logic [7:0]       ring;
  logic [3:0]       trans, count;
  logic             p1, p2;
  tsw_result_t      res;

  tsw_result_t           obuf [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OBUF_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  push, pop;

  assign cfg_ready = 1'b1;
  assign w = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign h = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_W'(640);
      height_r  <= DIM_W'(480);
      subiter_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r   <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r  <= cfg_data;
        CFG_SUBITERATION: subiter_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 0: position counters, store read
  assign in_stall  = (cnt_r + OBUF_CNT_W'(s1_r.valid)) > OBUF_CNT_W'(OBUF_DEPTH - 1);
  assign in_accept = in_valid && !in_stall;
  assign col_inc   = {1'b0, col_r} + (DIM_W+1)'(1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (row_r < h) begin
      if (col_inc >= {1'b0, w}) begin
        col_nxt = '0;
        row_nxt = row_r + DIM_W'(1);
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end else if (col_r >= w) begin
      row_nxt = '0;
      col_nxt = '0;
    end else begin
      col_nxt = col_inc[DIM_W-1:0];
    end
  end

  always_comb begin
    s1_nxt          = '0;
    s1_nxt.valid    = in_accept;
    s1_nxt.row      = row_r;
    s1_nxt.col      = col_r;
    s1_nxt.pix      = in_pixel_in && !in_drain;
    s1_nxt.in_frame = row_r < h;
    s1_nxt.col_ok   = col_r < DIM_W'(MAX_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      s1_r     <= '0;
    end else begin
      s1_r <= s1_nxt;
      if (in_accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  // line stores: read at accept, written back from stage 1
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_u_r <= line_upper[col_r[ADDR_W-1:0]];
    end
    if (s1_r.valid && s1_r.in_frame && s1_r.col_ok) begin
      line_upper[s1_r.col[ADDR_W-1:0]] <= rd_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_m_r <= line_middle[col_r[ADDR_W-1:0]];
    end
    if (s1_r.valid && s1_r.in_frame && s1_r.col_ok) begin
      line_middle[s1_r.col[ADDR_W-1:0]] <= s1_r.pix;
    end
  end

  // stage 1: window shift and decision
  assign u = s1_r.in_frame && s1_r.col_ok && rd_u_r;
  assign m = s1_r.col_ok && rd_m_r;
  assign l = s1_r.in_frame && s1_r.pix;
  assign win_nxt = {l, m, u, win_r[8:3]};
  assign center  = win_nxt[4];

  // ring order: N, NE, E, SE, S, SW, W, NW
  assign ring = {win_nxt[0], win_nxt[1], win_nxt[2], win_nxt[5],
                 win_nxt[8], win_nxt[7], win_nxt[6], win_nxt[3]};

  always_comb begin
    trans = '0;
    count = '0;
    for (int k = 0; k < 8; k++) begin
      if (!ring[k] && ring[(k + 1) % 8]) begin
        trans = trans + 4'd1;
      end
      count = count + 4'(ring[k]);
    end
  end

  always_comb begin
    if (!subiter_r) begin
      p1 = win_nxt[3] & win_nxt[7] & win_nxt[5];
      p2 = win_nxt[7] & win_nxt[5] & win_nxt[1];
    end else begin
      p1 = win_nxt[3] & win_nxt[7] & win_nxt[1];
      p2 = win_nxt[3] & win_nxt[5] & win_nxt[1];
    end
  end

  assign emit = (s1_r.row >= DIM_W'(2)) ||
                (s1_r.row == DIM_W'(1) && s1_r.col != '0);
  assign orow = (s1_r.col != '0) ? s1_r.row - DIM_W'(1) : s1_r.row - DIM_W'(2);
  assign ocol = (s1_r.col != '0) ? s1_r.col - DIM_W'(1) : w - DIM_W'(1);
  assign border = (orow == '0) || (orow >= h - DIM_W'(1)) ||
                  (ocol == '0) || (ocol >= w - DIM_W'(1));
  assign del = !border && center && trans == 4'd1 && count >= 4'd2 &&
               count <= 4'd6 && !p1 && !p2;
  assign last = (s1_r.row >= h) && (s1_r.col >= w);

  always_comb begin
    res.pixel_out     = center && !del;
    res.cleared       = del;
    res.frame_last    = last;
    res.frame_changed = last && (any_cleared_r || del);
  end

  always_comb begin
    any_cleared_nxt = any_cleared_r;
    if (s1_r.valid) begin
      if (s1_r.row >= h && s1_r.col >= w) begin
        any_cleared_nxt = 1'b0;
      end else if (emit) begin
        any_cleared_nxt = any_cleared_r || del;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r         <= '0;
      any_cleared_r <= 1'b0;
    end else begin
      any_cleared_r <= any_cleared_nxt;
      if (s1_r.valid) begin
        win_r <= win_nxt;
      end
    end
  end

  // output buffer
  assign push      = s1_r.valid && emit;
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign cnt_nxt   = cnt_r + OBUF_CNT_W'(push) - OBUF_CNT_W'(pop);

  assign out_pixel_out     = obuf[rd_ptr_r].pixel_out;
  assign out_cleared       = obuf[rd_ptr_r].cleared;
  assign out_frame_last    = obuf[rd_ptr_r].frame_last;
  assign out_frame_changed = obuf[rd_ptr_r].frame_changed;

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OBUF_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OBUF_PTR_W'(1);
      end
    end
  end

endmodule

### dv/thinning_subiteration_window_core_tb.sv
`timescale 1ns / 100ps

module thinning_subiteration_window_core_tb;
  import tsw_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_pixel_in = 1'b0;
  logic              in_drain = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_pixel_out;
  logic              out_cleared;
  logic              out_frame_last;
  logic              out_frame_changed;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;

  thinning_subiteration_window_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel_in       (in_pixel_in),
    .in_drain          (in_drain),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_out     (out_pixel_out),
    .out_cleared       (out_cleared),
    .out_frame_last    (out_frame_last),
    .out_frame_changed (out_frame_changed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // predictor state
  logic [DIM_W-1:0] width_reg = 11'd640;
  logic [DIM_W-1:0] height_reg = 11'd480;
  logic             sub_reg = 1'b0;
  bit               store_upper [MAX_WIDTH];
  bit               store_middle [MAX_WIDTH];
  bit [8:0]         window_bits;
  int               col_pos;
  int               row_pos;
  bit               frame_cleared;

  tsw_result_t thinned_pixels_due [$];

  int src_idle_pct;
  int sink_stall_pct;
  int beats_sent;
  int frames_sent;
  int results_seen;
  int pixels_cleared;
  int frames_changed;
  int err_count;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("%0t: timeout", $time);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
    int d;
    d = int'(v);
    if (d < MIN_DIM) begin
      d = MIN_DIM;
    end else if (d > hi) begin
      d = hi;
    end
    return d;
  endfunction

  function automatic bit zs_removable(input bit [8:0] wb, input logic sub);
    bit nn, ne, ee, se, ss, sw, ww, nw, p1, p2;
    bit [7:0] ring;
    int k, trans, cnt;
    nw = wb[0];
    ww = wb[1];
    sw = wb[2];
    nn = wb[3];
    ss = wb[5];
    ne = wb[6];
    ee = wb[7];
    se = wb[8];
    ring = {nw, ww, sw, ss, se, ee, ne, nn};
    trans = 0;
    cnt = 0;
    for (k = 0; k < 8; k++) begin
      if (!ring[k] && ring[(k + 1) % 8]) trans++;
      cnt += ring[k];
    end
    p1 = sub ? (nn & ee & ww) : (nn & ee & ss);
    p2 = sub ? (nn & ss & ww) : (ee & ss & ww);
    return trans == 1 && cnt >= 2 && cnt <= 6 && !p1 && !p2;
  endfunction

  function automatic void thin_pixel_step(input logic pin, input logic drn);
    int w, h, orow, ocol;
    bit pix, u, m, l, center, del, border;
    tsw_result_t r;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    pix = drn ? 1'b0 : pin;
    u = 1'b0;
    m = 1'b0;
    l = 1'b0;
    if (row_pos < h) begin
      if (col_pos < MAX_WIDTH) begin
        u = store_upper[col_pos];
        m = store_middle[col_pos];
        store_upper[col_pos] = m;
        store_middle[col_pos] = pix;
      end
      l = pix;
    end else if (col_pos < MAX_WIDTH) begin
      m = store_middle[col_pos];
    end
    window_bits = {l, m, u, window_bits[8:3]};

    if (row_pos >= 2 || (row_pos == 1 && col_pos >= 1)) begin
      orow = (col_pos > 0) ? row_pos - 1 : row_pos - 2;
      ocol = (col_pos > 0) ? col_pos - 1 : w - 1;
      center = window_bits[4];
      border = orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1;
      del = !border && center && zs_removable(window_bits, sub_reg);
      frame_cleared |= del;
      r.pixel_out = center & ~del;
      r.cleared = del;
      r.frame_last = row_pos >= h && col_pos >= w;
      r.frame_changed = r.frame_last & frame_cleared;
      thinned_pixels_due = {thinned_pixels_due, r};
      if (r.frame_last) frames_sent++;
    end

    if (row_pos < h) begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end else if (col_pos >= w) begin
      row_pos = 0;
      col_pos = 0;
      frame_cleared = 1'b0;
    end else begin
      col_pos++;
    end
  endfunction

  always @(posedge clk) begin
    tsw_result_t want;
    logic [3:0] got;
    string names [4];
    int k;
    names = '{"frame_changed", "frame_last", "cleared", "pixel_out"};
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pixel_out, out_cleared, out_frame_last, out_frame_changed};
      if (thinned_pixels_due.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, got %b", $time, got);
      end else begin
        want = thinned_pixels_due.pop_front();
        results_seen++;
        if (want.cleared) pixels_cleared++;
        if (want.frame_changed) frames_changed++;
        for (k = 0; k < 4; k++) begin
          if (got[k] !== want[k]) begin
            err_count++;
            $display("%0t: %s mismatch, expected %b, got %b",
                     $time, names[k], want[k], got[k]);
          end
        end
      end
    end
  end

  task automatic send_pixel(input logic pix, input logic drn);
    logic taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= pix;
    in_drain <= drn;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
    thin_pixel_step(pix, drn);
  endtask

  task automatic send_random_beat(input int density, input int noise);
    if (row_pos < eff_dim(height_reg, MAX_HEIGHT))
      send_pixel($urandom_range(99) < density, $urandom_range(99) < noise);
    else
      send_pixel(1'($urandom_range(1)), !($urandom_range(99) < noise));
  endtask

  task automatic run_frame(input int density, input int noise);
    do begin
      send_random_beat(density, noise);
    end while (row_pos != 0 || col_pos != 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (thinned_pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [DIM_W-1:0] wd, input logic [DIM_W-1:0] ht,
                                input logic sub, input bit poke_spare);
    logic [CIDX_W-1:0] idx [4];
    logic [DIM_W-1:0]  val [4];
    logic              taken;
    int                i, n;
    settle();
    idx = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_SUBITERATION, CFG_SPARE};
    val = '{wd, ht, DIM_W'(sub), {DIM_W{1'b1}}};
    n = poke_spare ? 4 : 3;
    for (i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do begin
        @(negedge clk);
        taken = cfg_ready;
        @(posedge clk);
      end while (!taken);
      case (idx[i])
        CFG_IMAGE_WIDTH:  width_reg = val[i];
        CFG_IMAGE_HEIGHT: height_reg = val[i];
        CFG_SUBITERATION: sub_reg = val[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    int r, c, i;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    for (i = 0; i < 2; i++) begin
      apply_settings(11'd5, 11'd5, i[0], 1'b0);
      for (r = 0; r < 5; r++)
        for (c = 0; c < 5; c++)
          send_pixel((r inside {[1:3]}) && (c inside {[1:3]}), 1'b0);
      for (c = 0; c < 6; c++) send_pixel(1'b0, 1'b1);
    end
    // all-ones frame, early drain mid-frame, live pixels in the tail
    apply_settings(11'd4, 11'd4, 1'b0, 1'b0);
    for (i = 0; i < 16; i++) send_pixel(1'b1, i == 6);
    for (i = 0; i < 5; i++) send_pixel(1'b1, i[0]);
  endtask

  task automatic test_geometry_extremes();
    int i;
    src_idle_pct = 7;
    sink_stall_pct = 7;
    // widest row, then the width drops to the current column
    apply_settings(11'd2047, 11'd0, 1'b0, 1'b1);
    for (i = 0; i < MAX_WIDTH + 4; i++) send_random_beat(50, 0);
    apply_settings(11'd4, 11'd0, 1'b0, 1'b0);
    run_frame(50, 0);
    // tall frame cut short once the row is past the new height
    apply_settings(11'd1, 11'd1500, 1'b1, 1'b0);
    for (i = 0; i < 30; i++) send_random_beat(65, 2);
    apply_settings(11'd1, 11'd3, 1'b1, 1'b0);
    run_frame(65, 2);
    apply_settings(11'd3, 11'd2, 1'b1, 1'b0);
    run_frame(100, 0);
  endtask

  task automatic test_midframe_geometry();
    int i;
    src_idle_pct = 7;
    sink_stall_pct = 7;
    apply_settings(11'd10, 11'd10, 1'b0, 1'b0);
    for (i = 0; i < 34; i++) send_random_beat(60, 0);
    apply_settings(11'd7, 11'd12, 1'b1, 1'b0);
    run_frame(60, 0);
    apply_settings(11'd12, 11'd12, 1'b0, 1'b0);
    for (i = 0; i < 69; i++) send_random_beat(60, 0);
    apply_settings(11'd6, 11'd4, 1'b0, 1'b0);
    run_frame(60, 0);
  endtask

  task automatic test_random_frames();
    int src_pct [4];
    int sink_pct [4];
    int goal, p;
    src_pct = '{0, 49, 0, 7};
    sink_pct = '{0, 0, 49, 7};
    goal = beats_sent;
    for (p = 0; p < 4; p++) begin
      src_idle_pct = src_pct[p];
      sink_stall_pct = sink_pct[p];
      goal += 90;
      while (beats_sent < goal) begin
        apply_settings(DIM_W'($urandom_range(14)), DIM_W'($urandom_range(12)),
                       1'($urandom_range(1)), 1'b0);
        run_frame($urandom_range(90, 25), ($urandom_range(4) == 0) ? 8 : 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_geometry_extremes();
    test_midframe_geometry();
    test_random_frames();
    settle();
    $display("Sent %0d pixel beats over %0d frames; checked %0d results.",
             beats_sent, frames_sent, results_seen);
    $display("Saw %0d cleared pixels and %0d frames flagged as changed.",
             pixels_cleared, frames_changed);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
design/tsw_pkg.sv
design/thinning_subiteration_window_core.sv
dv/thinning_subiteration_window_core_tb.sv
